@@ rtl/fbtu_pkg.sv @@
package fbtu_pkg;

    localparam int unsigned CODE_W     = 5;
    localparam int unsigned WORD_W     = 16;
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned LEN_W      = 16;
    localparam int unsigned CODES_PER  = 3;
    localparam int unsigned CNT_W      = 2;

    localparam logic [CODE_W-1:0] CODE_SPACE  = 5'h00;
    localparam logic [CODE_W-1:0] CODE_ESCAPE = 5'h1e;
    localparam logic [CODE_W-1:0] PUNCT_COUNT = 5'd23;
    localparam logic [CHAR_W-1:0] SPACE_CHAR    = 8'h20;
    localparam logic [CHAR_W-1:0] LETTER_OFFSET = 8'h60;
    localparam logic [CHAR_W-1:0] BAD_CHAR      = 8'h00;
    localparam logic [LEN_W-1:0]  LEN_RESET     = 16'd1;

    // Decoder state carried from one word to the next.
    typedef struct packed {
        logic             esc;
        logic             finished;
        logic [LEN_W-1:0] remaining;
    } t_state;

    // One decoded character with its flags.
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              bad;
    } t_item;

    // Punctuation table selected by an escape index below PUNCT_COUNT.
    function automatic logic [CHAR_W-1:0] punct_char(input logic [CODE_W-1:0] idx);
        logic [CHAR_W-1:0] c;
        case (idx)
            5'd0:    c = 8'h00;
            5'd1:    c = 8'h09;
            5'd2:    c = 8'h0a;
            5'd3:    c = 8'h21;
            5'd4:    c = 8'h22;
            5'd5:    c = 8'h28;
            5'd6:    c = 8'h29;
            5'd7:    c = 8'h2c;
            5'd8:    c = 8'h2d;
            5'd9:    c = 8'h2e;
            5'd10:   c = 8'h2f;
            5'd11:   c = 8'h3a;
            5'd12:   c = 8'h43;
            5'd13:   c = 8'h46;
            5'd14:   c = 8'h47;
            5'd15:   c = 8'h48;
            5'd16:   c = 8'h49;
            5'd17:   c = 8'h53;
            5'd18:   c = 8'h54;
            5'd19:   c = 8'h59;
            5'd20:   c = 8'h5b;
            5'd21:   c = 8'h5d;
            5'd22:   c = 8'h5f;
            default: c = BAD_CHAR;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/fbtu_decode.sv @@
module fbtu_decode
    import fbtu_pkg::*;
(
    input  logic [WORD_W-1:0] i_word,
    input  t_state            i_state,
    output t_state            o_state,
    output t_item             o_items [CODES_PER],
    output logic [CNT_W-1:0]  o_count
);

    // Walk the three codes in order, packing emitted characters from slot 0 up.
    always_comb begin
        t_state            st;
        logic [CODE_W-1:0] code;
        logic              emit;
        logic [CHAR_W-1:0] ch;
        logic              bad;
        logic [CNT_W-1:0]  idx;
        st   = i_state;
        idx  = '0;
        code = '0;
        emit = 1'b0;
        ch   = '0;
        bad  = 1'b0;
        for (int k = 0; k < CODES_PER; k++) begin
            o_items[k] = '0;
        end
        for (int k = 0; k < CODES_PER; k++) begin
            code = i_word[CODE_W*(CODES_PER-1-k) +: CODE_W];
            emit = 1'b0;
            ch   = '0;
            bad  = 1'b0;
            if (!st.finished) begin
                if (st.esc) begin
                    st.esc = 1'b0;
                    emit   = 1'b1;
                    if (code < PUNCT_COUNT) begin
                        ch = punct_char(code);
                    end else begin
                        ch  = BAD_CHAR;
                        bad = 1'b1;
                    end
                end else if (code == CODE_ESCAPE) begin
                    st.esc = 1'b1;
                end else if (code == CODE_SPACE) begin
                    emit = 1'b1;
                    ch   = SPACE_CHAR;
                end else begin
                    emit = 1'b1;
                    ch   = {{(CHAR_W-CODE_W){1'b0}}, code} + LETTER_OFFSET;
                end
            end
            if (emit) begin
                st.remaining = st.remaining - 1'b1;
                if (st.remaining == '0) begin
                    st.finished = 1'b1;
                end
                o_items[idx].ch   = ch;
                o_items[idx].last = (st.remaining == '0);
                o_items[idx].bad  = bad;
                idx = idx + 1'b1;
            end
        end
        o_state = st;
        o_count = idx;
    end

endmodule

@@ rtl/five_bit_text_unpacker.sv @@
// Five-bit text unpacker. Each input word carries three 5-bit codes (bits 14..10 first,
// bit 15 ignored) and is decoded in the cycle it is accepted into a three-entry result
// buffer, which drains one character per cycle while m_axis_tready is high. The next word
// is taken in the cycle the buffer's final character leaves, or when it is empty, so words
// yielding fewer characters go faster, down to one per cycle. Writing the message length
// restarts decoding; after the flagged last character all codes are dropped until the
// next write. Configuration must be written while idle; the block does not enforce it.
module five_bit_text_unpacker
    import fbtu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [LEN_W-1:0]   i_cfg_wr_data,  // message_length
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [WORD_W-1:0]  s_axis_tdata,   // [15:0] packed_word
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [CHAR_W-1:0]  m_axis_tdata,   // [7:0] character
    output logic               m_axis_tlast,   // last_char
    output logic               m_axis_tuser    // [0] bad_index
);

    t_state           r_state;
    t_item            r_items [CODES_PER];
    logic [CNT_W-1:0] r_cnt;

    t_state           n_state;
    t_item            n_items [CODES_PER];
    logic [CNT_W-1:0] n_cnt;

    logic pop;
    logic accept;

    fbtu_decode u_decode (
        .i_word  (s_axis_tdata),
        .i_state (r_state),
        .o_state (n_state),
        .o_items (n_items),
        .o_count (n_cnt)
    );

    // Handshake: a new word enters once the buffer is empty or its final character leaves.
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && pop);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tdata  = r_items[0].ch;
    assign m_axis_tlast  = r_items[0].last;
    assign m_axis_tuser  = r_items[0].bad;

    // Decoder state and buffer fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.esc       <= 1'b0;
            r_state.finished  <= 1'b0;
            r_state.remaining <= LEN_RESET;
            r_cnt             <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_state.esc       <= 1'b0;
                r_state.finished  <= (i_cfg_wr_data == '0);
                r_state.remaining <= i_cfg_wr_data;
            end else if (accept) begin
                r_state <= n_state;
            end
            if (accept) begin
                r_cnt <= n_cnt;
            end else if (pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Result buffer: load on a new word, otherwise shift towards slot 0 as characters leave.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int k = 0; k < CODES_PER; k++) begin
                r_items[k] <= n_items[k];
            end
        end else if (pop) begin
            for (int k = 0; k < CODES_PER-1; k++) begin
                r_items[k] <= r_items[k+1];
            end
        end
    end

endmodule
